@@ rtl/thrq_pkg.sv @@
`default_nettype none

package thrq_pkg;

    // Field widths of the request and result
    localparam int OP_W   = 3;
    localparam int QSEL_W = 3;
    localparam int ID_W   = 6;
    localparam int STAT_W = 2;

    // Default sizes of the link store and the queue tables
    localparam int DEF_MAX_THREADS = 64;
    localparam int DEF_NUM_QUEUES  = 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT2 = 3'd1;
    localparam logic [OP_W-1:0] OP_POP     = 3'd2;
    localparam logic [OP_W-1:0] OP_SIGNAL  = 3'd3;
    localparam logic [OP_W-1:0] OP_BCAST   = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ILLEGAL = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [QSEL_W-1:0] queue_sel;
        logic [ID_W-1:0]   thread_id;
    } t_request;

    typedef struct packed {
        logic [ID_W-1:0]   out_thread;
        logic [STAT_W-1:0] status;
    } t_result;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_UPDATE,
        S_LINK2
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic fetch;
        logic update;
        logic link2;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic two_writes;
    } t_sts;

endpackage

`default_nettype wire

@@ rtl/thrq_ctrl.sv @@
`default_nettype none

module thrq_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  thrq_pkg::t_sts   i_sts,
    output thrq_pkg::t_cmd   o_cmd,
    output logic             o_busy
);
    import thrq_pkg::*;

    t_state r_state;
    t_state n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequence one request: capture, fetch link, update, optional second link write
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = i_sts.two_writes ? S_LINK2 : S_IDLE;
            end
            S_LINK2: begin
                o_cmd.link2 = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/thrq_dp.sv @@
`default_nettype none

module thrq_dp #(
    parameter int MAX_THREADS = thrq_pkg::DEF_MAX_THREADS,
    parameter int NUM_QUEUES  = thrq_pkg::DEF_NUM_QUEUES
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  thrq_pkg::t_request  i_req,
    input  thrq_pkg::t_cmd      i_cmd,
    output thrq_pkg::t_sts      o_sts,
    output logic                o_done,
    output thrq_pkg::t_result   o_result
);
    import thrq_pkg::*;

    localparam int TW = $clog2(MAX_THREADS);
    localparam int QW = $clog2(NUM_QUEUES);

    // Latched request
    logic [OP_W-1:0]   r_op;
    logic [QSEL_W-1:0] r_qs;
    logic [ID_W-1:0]   r_tid;

    // Queue tables (entry 0 unused: the run queue lives in registers)
    logic [ID_W-1:0]   r_head_mem [NUM_QUEUES];
    logic [ID_W-1:0]   r_tail_mem [NUM_QUEUES];
    logic [ID_W-1:0]   r_hd_rd;
    logic [ID_W-1:0]   r_tl_rd;
    logic [ID_W-1:0]   r_run_head;
    logic [ID_W-1:0]   r_run_tail;
    logic [NUM_QUEUES-1:0] r_nonempty;

    // Shared next-link store
    logic [ID_W-1:0]   r_link_mem [MAX_THREADS];
    logic [ID_W-1:0]   r_link_rd;

    t_result r_result;
    logic    r_done;

    logic              q_ok;
    logic              tid_ok;
    logic              is_run;
    logic [QW-1:0]     qidx;
    logic              cur_ne;
    logic [ID_W-1:0]   cur_h;
    logic [ID_W-1:0]   cur_t;

    logic [STAT_W-1:0] n_status;
    logic [ID_W-1:0]   n_outt;
    logic              lk_we;
    logic [ID_W-1:0]   lk_wa;
    logic [ID_W-1:0]   lk_wd;
    logic              hq_we;
    logic [ID_W-1:0]   hq_wd;
    logic              tq_we;
    logic              ne_set;
    logic              ne_clr;
    logic              h0_we;
    logic              t0_we;
    logic [ID_W-1:0]   t0_wd;
    logic              ne0_set;

    logic              link_we;
    logic [ID_W-1:0]   link_wa;
    logic [ID_W-1:0]   link_wd;

    // Decode the latched request and select the addressed queue
    assign q_ok   = 32'(r_qs) < NUM_QUEUES;
    assign tid_ok = 32'(r_tid) < MAX_THREADS;
    assign is_run = (r_qs == '0);
    assign qidx   = QW'(r_qs);
    assign cur_ne = q_ok ? r_nonempty[qidx] : 1'b0;
    assign cur_h  = is_run ? r_run_head : r_hd_rd;
    assign cur_t  = is_run ? r_run_tail : r_tl_rd;

    // Work out the result and every table update of the request
    always_comb begin
        n_status = STAT_ILLEGAL;
        n_outt   = '0;
        lk_we    = 1'b0;
        lk_wa    = cur_t;
        lk_wd    = r_tid;
        hq_we    = 1'b0;
        hq_wd    = r_tid;
        tq_we    = 1'b0;
        ne_set   = 1'b0;
        ne_clr   = 1'b0;
        h0_we    = 1'b0;
        t0_we    = 1'b0;
        t0_wd    = cur_h;
        ne0_set  = 1'b0;
        if (q_ok) begin
            case (r_op)
                OP_APPEND, OP_INSERT2: begin
                    if (tid_ok) begin
                        n_status = STAT_OK;
                        if (!cur_ne) begin
                            hq_we  = 1'b1;
                            tq_we  = 1'b1;
                            ne_set = 1'b1;
                        end else if (r_op == OP_APPEND) begin
                            lk_we = 1'b1;
                            lk_wa = cur_t;
                            lk_wd = r_tid;
                            tq_we = 1'b1;
                        end else begin
                            // new thread takes over the head's successor
                            lk_we = 1'b1;
                            lk_wa = r_tid;
                            lk_wd = r_link_rd;
                            tq_we = (cur_t == cur_h);
                        end
                    end
                end
                OP_POP: begin
                    if (!cur_ne) begin
                        n_status = STAT_EMPTY;
                    end else begin
                        n_status = STAT_OK;
                        n_outt   = cur_h;
                        if (cur_t == cur_h) begin
                            ne_clr = 1'b1;
                        end else begin
                            hq_we = 1'b1;
                            hq_wd = r_link_rd;
                        end
                    end
                end
                OP_SIGNAL: begin
                    if (!is_run) begin
                        if (!cur_ne) begin
                            n_status = STAT_EMPTY;
                        end else begin
                            n_status = STAT_OK;
                            n_outt   = cur_h;
                            if (cur_t == cur_h) begin
                                ne_clr = 1'b1;
                            end else begin
                                hq_we = 1'b1;
                                hq_wd = r_link_rd;
                            end
                            // append the popped thread to the run queue
                            if (r_nonempty[0]) begin
                                lk_we = 1'b1;
                                lk_wa = r_run_tail;
                                lk_wd = cur_h;
                            end else begin
                                h0_we = 1'b1;
                            end
                            t0_we   = 1'b1;
                            t0_wd   = cur_h;
                            ne0_set = 1'b1;
                        end
                    end
                end
                OP_BCAST: begin
                    if (!is_run) begin
                        if (!cur_ne) begin
                            n_status = STAT_EMPTY;
                        end else begin
                            n_status = STAT_OK;
                            // splice the whole list onto the run queue
                            if (r_nonempty[0]) begin
                                lk_we = 1'b1;
                                lk_wa = r_run_tail;
                                lk_wd = cur_h;
                            end else begin
                                h0_we = 1'b1;
                            end
                            t0_we   = 1'b1;
                            t0_wd   = cur_t;
                            ne0_set = 1'b1;
                            ne_clr  = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Insert second on a non-empty queue needs a second link write
    assign o_sts.two_writes = q_ok && tid_ok && (r_op == OP_INSERT2) && cur_ne;

    // Pick the link write of this cycle
    assign link_we = (i_cmd.update && lk_we) || i_cmd.link2;
    assign link_wa = i_cmd.link2 ? cur_h : lk_wa;
    assign link_wd = i_cmd.link2 ? r_tid : lk_wd;

    // Link store: one write port, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch) begin
            r_link_rd <= r_link_mem[TW'(cur_h)];
        end
        if (link_we) begin
            r_link_mem[TW'(link_wa)] <= link_wd;
        end
    end

    // Queue tables: registered read at capture, write at update
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_hd_rd <= r_head_mem[QW'(i_req.queue_sel)];
            r_tl_rd <= r_tail_mem[QW'(i_req.queue_sel)];
        end
        if (i_cmd.update && !is_run) begin
            if (hq_we) begin
                r_head_mem[qidx] <= hq_wd;
            end
            if (tq_we) begin
                r_tail_mem[qidx] <= r_tid;
            end
        end
    end

    // Latch the request, update run-queue pointers, register the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_req.op;
            r_qs  <= i_req.queue_sel;
            r_tid <= i_req.thread_id;
        end
        if (i_cmd.update) begin
            r_result.out_thread <= n_outt;
            r_result.status     <= n_status;
            if (is_run && hq_we) begin
                r_run_head <= hq_wd;
            end
            if (is_run && tq_we) begin
                r_run_tail <= r_tid;
            end
            if (h0_we) begin
                r_run_head <= cur_h;
            end
            if (t0_we) begin
                r_run_tail <= t0_wd;
            end
        end
    end

    // Occupancy flags and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nonempty <= '0;
            r_done     <= 1'b0;
        end else begin
            r_done <= i_cmd.update;
            if (i_cmd.update) begin
                if (ne_set) begin
                    r_nonempty[qidx] <= 1'b1;
                end
                if (ne_clr) begin
                    r_nonempty[qidx] <= 1'b0;
                end
                if (ne0_set) begin
                    r_nonempty[0] <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

@@ rtl/thread_run_queue_engine.sv @@
`default_nettype none

// Takes one request at a time: capture, fetch, update; insert-second into a non-empty queue adds
// a second link-write step, since the single write port of the link store needs two writes for it.
// The request is captured with registered reads of the queue tables, the link store is read in the
// fetch step, and the result and o_done are registered from the update step.
// The receiver cannot stall: each result is valid for exactly one cycle.
// Synchronous active-low reset idles the controller and marks every queue empty.
module thread_run_queue_engine #(
    parameter int MAX_THREADS = thrq_pkg::DEF_MAX_THREADS,
    parameter int NUM_QUEUES  = thrq_pkg::DEF_NUM_QUEUES
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  thrq_pkg::t_request  i_req,
    output logic                o_done,
    output thrq_pkg::t_result   o_result
);
    import thrq_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    thrq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    thrq_dp #(
        .MAX_THREADS (MAX_THREADS),
        .NUM_QUEUES  (NUM_QUEUES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // A result strobe follows only an update step
    a_done_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_cmd.update))
        else $error("result strobe without update step");

    // A taken request keeps the block busy in the next cycle
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after request taken");

    // At most one command at a time
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("more than one datapath command");

    // A reported status is always a defined code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.status == STAT_OK || o_result.status == STAT_EMPTY ||
                    o_result.status == STAT_ILLEGAL))
        else $error("undefined status code");

endmodule

`default_nettype wire
